// ===== src/csa_pkg.sv =====
`default_nettype none
package csa_pkg;

  localparam int unsigned MaxRowsDef = 1024;
  localparam int unsigned MaxNzDef   = 16384;

  localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
  localparam logic [1:0] CMD_LOAD_COL = 2'd1;
  localparam logic [1:0] CMD_ACC      = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD_ROW,
    OP_LOAD_COL,
    OP_DONE,
    OP_ZERO,
    OP_ABSENT,
    OP_ACC,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [10:0] row;
    logic [14:0] position;
    logic [9:0]  column;
    logic [63:0] value;
  } item_t;

endpackage
`default_nettype wire

// ===== src/csa_front.sv =====
`default_nettype none
module csa_front import csa_pkg::*; #(
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned MAX_NONZEROS = MaxNzDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [10:0] row_i,
  input  wire logic [14:0] position_i,
  input  wire logic [9:0]  column_i,
  input  wire logic [63:0] value_i,
  input  wire logic        back_ready_i,
  output logic             head_valid_o,
  output item_t            head_o,
  input  wire logic        pop_i
);

  logic [10:0] dof_count_q;
  item_t       entry;
  item_t       q_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dof_count_q <= '0;
    end else if (cfg_we_i) begin
      dof_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    entry.row      = row_i;
    entry.position = position_i;
    entry.column   = column_i;
    entry.value    = value_i;
    case (cmd_i)
      CMD_LOAD_ROW: entry.op = (32'(row_i) <= MAX_ROWS) ? OP_LOAD_ROW : OP_DONE;
      CMD_LOAD_COL: entry.op = (32'(position_i) < MAX_NONZEROS) ? OP_LOAD_COL : OP_DONE;
      CMD_ACC: begin
        if (value_i[62:0] == 63'd0) begin
          entry.op = OP_ZERO;
        end else if (row_i >= dof_count_q || 32'(row_i) >= MAX_ROWS) begin
          entry.op = OP_ABSENT;
        end else begin
          entry.op = OP_ACC;
        end
      end
      CMD_READ: entry.op = (32'(position_i) < MAX_NONZEROS) ? OP_READ : OP_ABSENT;
      default:  entry.op = OP_DONE;
    endcase
  end

  // no requests taken while the queue is full or until the value store has been swept clear
  assign in_stall_o   = (cnt_q == 2'd2) || !back_ready_i;
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== src/csa_fadd.sv =====
`default_nettype none
module csa_fadd (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      sum_o
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_ALIGN = 3'd1;
  localparam logic [2:0] F_ADD   = 3'd2;
  localparam logic [2:0] F_POST  = 3'd3;
  localparam logic [2:0] F_NORM  = 3'd4;
  localparam logic [2:0] F_ROUND = 3'd5;

  logic [2:0]  state_q;
  logic [2:0]  nstep_q;
  logic        sign_q, sub_q, zsign_q, spec_q;
  logic [63:0] spec_res_q;
  logic [11:0] e_q;
  logic [55:0] ma_q, mb_q;
  logic [10:0] d_q;
  logic [56:0] s_q;
  logic        done_q;
  logic [63:0] sum_q;

  // unpack and order operands by magnitude
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0] big, sml;
  logic [10:0] eb_eff, es_eff;
  logic [63:0] spec_res;

  always_comb begin
    a_nan  = (&a_i[62:52]) && (|a_i[51:0]);
    b_nan  = (&b_i[62:52]) && (|b_i[51:0]);
    a_inf  = (&a_i[62:52]) && !(|a_i[51:0]);
    b_inf  = (&b_i[62:52]) && !(|b_i[51:0]);
    swap   = b_i[62:0] > a_i[62:0];
    big    = swap ? b_i : a_i;
    sml    = swap ? a_i : b_i;
    eb_eff = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es_eff = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    if (a_nan) begin
      spec_res = {a_i[63], 12'hfff, a_i[50:0]};
    end else if (b_nan) begin
      spec_res = {b_i[63], 12'hfff, b_i[50:0]};
    end else if (a_inf && b_inf && (a_i[63] != b_i[63])) begin
      spec_res = 64'hfff8_0000_0000_0000;
    end else if (a_inf) begin
      spec_res = a_i;
    end else begin
      spec_res = b_i;
    end
  end

  logic [10:0] dd;
  logic [55:0] shifted;
  logic        sticky;
  logic [5:0]  sh;
  logic        topz;

  always_comb begin
    dd      = (d_q >= 11'd56) ? 11'd56 : d_q;
    shifted = mb_q >> dd;
    sticky  = |(mb_q & ~({56{1'b1}} << dd));
    sh      = 6'd32 >> nstep_q;
    topz    = ((s_q[55:0] & ~({56{1'b1}} >> sh)) == 56'd0);
  end

  logic        g, rsb, rup;
  logic [52:0] mant;
  logic [53:0] mr;
  logic [11:0] efin;
  logic [51:0] frac;
  logic [63:0] rounded;

  always_comb begin
    mant = s_q[55:3];
    g    = s_q[2];
    rsb  = |s_q[1:0];
    rup  = g && (rsb || mant[0]);
    mr   = {1'b0, mant} + 54'(rup);
    if (mr[53]) begin
      efin = e_q + 12'd1;
      frac = mr[52:1];
    end else begin
      efin = mr[52] ? e_q : 12'd0;
      frac = mr[51:0];
    end
    if (spec_q) begin
      rounded = spec_res_q;
    end else if (s_q == 57'd0) begin
      rounded = {zsign_q, 63'd0};
    end else if (efin >= 12'd2047) begin
      rounded = {sign_q, 11'h7ff, 52'd0};
    end else begin
      rounded = {sign_q, efin[10:0], frac};
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          sign_q     <= big[63];
          sub_q      <= a_i[63] ^ b_i[63];
          zsign_q    <= a_i[63] & b_i[63];
          spec_q     <= (&a_i[62:52]) || (&b_i[62:52]);
          spec_res_q <= spec_res;
          e_q        <= {1'b0, eb_eff};
          ma_q       <= {big[62:52] != 11'd0, big[51:0], 3'b000};
          mb_q       <= {sml[62:52] != 11'd0, sml[51:0], 3'b000};
          d_q        <= eb_eff - es_eff;
        end
      end
      F_ALIGN: mb_q <= {shifted[55:1], shifted[0] | sticky};
      F_ADD: begin
        s_q <= sub_q ? ({1'b0, ma_q} - {1'b0, mb_q}) : ({1'b0, ma_q} + {1'b0, mb_q});
      end
      F_POST: begin
        if (s_q[56]) begin
          s_q <= {1'b0, s_q[56:2], s_q[1] | s_q[0]};
          e_q <= e_q + 12'd1;
        end
      end
      F_NORM: begin
        // shift left by this step's amount unless it would leave the normal range
        if (topz && (e_q > 12'(sh))) begin
          s_q <= {1'b0, s_q[55:0] << sh};
          e_q <= e_q - 12'(sh);
        end
      end
      F_ROUND: sum_q <= rounded;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      nstep_q <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            state_q <= ((&a_i[62:52]) || (&b_i[62:52])) ? F_ROUND : F_ALIGN;
          end
        end
        F_ALIGN: state_q <= F_ADD;
        F_ADD:   state_q <= F_POST;
        F_POST: begin
          state_q <= F_NORM;
          nstep_q <= 3'd0;
        end
        F_NORM: begin
          nstep_q <= nstep_q + 3'd1;
          if (nstep_q == 3'd5) begin
            state_q <= F_ROUND;
          end
        end
        F_ROUND: begin
          state_q <= F_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule
`default_nettype wire

// ===== src/csa_back.sv =====
`default_nettype none
module csa_back import csa_pkg::*; #(
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned MAX_NONZEROS = MaxNzDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  item_t            head_i,
  output logic             pop_o,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [13:0]      found_position_o,
  output logic [63:0]      sum_o
);

  localparam int unsigned RS_DEPTH = MAX_ROWS + 1;
  localparam int unsigned RS_AW    = $clog2(RS_DEPTH);
  localparam int unsigned POS_AW   = $clog2(MAX_NONZEROS);
  localparam int unsigned PW       = $clog2(MAX_NONZEROS + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RS0   = 4'd2;
  localparam logic [3:0] S_RS1   = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_PROBE = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_VAL   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;

  logic [3:0]        state_q;
  item_t             cur_q;
  logic [POS_AW-1:0] clr_q;
  logic [PW-1:0]     lo_q, hi_q, end_q, mid_q;

  logic              res_valid_q;
  logic [1:0]        res_status_q;
  logic [13:0]       res_pos_q;
  logic [63:0]       res_sum_q;

  // memories
  logic [14:0]       rs_mem [RS_DEPTH];
  logic [9:0]        col_mem [MAX_NONZEROS];
  logic [63:0]       val_mem [MAX_NONZEROS];
  logic [14:0]       rs_rdata_q;
  logic [9:0]        col_rdata_q;
  logic [63:0]       val_rdata_q;

  logic              rs_we, rs_re, col_we, col_re, val_we, val_re;
  logic [RS_AW-1:0]  rs_addr;
  logic [POS_AW-1:0] col_addr, val_addr;
  logic [63:0]       val_wdata;

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_addr] <= head_i.position;
    end
    if (rs_re) begin
      rs_rdata_q <= rs_mem[rs_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_addr] <= head_i.column;
    end
    if (col_re) begin
      col_rdata_q <= col_mem[col_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_addr] <= val_wdata;
    end
    if (val_re) begin
      val_rdata_q <= val_mem[val_addr];
    end
  end

  logic          add_start, add_done;
  logic [63:0]   add_sum;

  csa_fadd u_fadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (add_start),
    .a_i     (val_rdata_q),
    .b_i     (cur_q.value),
    .done_o  (add_done),
    .sum_o   (add_sum)
  );

  function automatic logic [PW-1:0] clamp_pos(input logic [14:0] p);
    return (32'(p) > MAX_NONZEROS) ? PW'(MAX_NONZEROS) : PW'(p);
  endfunction

  logic [31:0]   row_ext, row_next, head_pos_ext;
  logic [PW-1:0] rs_clamped, mid;
  logic          take;

  always_comb begin
    row_ext      = 32'(head_i.row);
    row_next     = 32'(cur_q.row) + 32'd1;
    head_pos_ext = 32'(head_i.position);
    rs_clamped   = clamp_pos(rs_rdata_q);
    mid          = lo_q + ((hi_q - lo_q) >> 1);
    take         = (state_q == S_IDLE) && head_valid_i && !res_valid_q;

    rs_we     = 1'b0;
    rs_re     = 1'b0;
    col_we    = 1'b0;
    col_re    = 1'b0;
    val_we    = 1'b0;
    val_re    = 1'b0;
    rs_addr   = row_ext[RS_AW-1:0];
    col_addr  = head_pos_ext[POS_AW-1:0];
    val_addr  = head_pos_ext[POS_AW-1:0];
    val_wdata = 64'd0;
    add_start = 1'b0;

    case (state_q)
      S_CLEAR: begin
        val_we   = 1'b1;
        val_addr = clr_q;
      end
      S_IDLE: begin
        if (take) begin
          case (head_i.op)
            OP_LOAD_ROW: rs_we  = 1'b1;
            OP_LOAD_COL: col_we = 1'b1;
            OP_ACC:      rs_re  = 1'b1;
            OP_READ:     val_re = 1'b1;
            default: ;
          endcase
        end
      end
      S_RS0: begin
        rs_re   = 1'b1;
        rs_addr = row_next[RS_AW-1:0];
      end
      S_SRCH: begin
        col_re   = 1'b1;
        col_addr = (lo_q < hi_q) ? mid[POS_AW-1:0] : lo_q[POS_AW-1:0];
      end
      S_CHK: begin
        val_re   = 1'b1;
        val_addr = lo_q[POS_AW-1:0];
      end
      S_VAL: add_start = 1'b1;
      S_ADD: begin
        val_we    = add_done;
        val_addr  = lo_q[POS_AW-1:0];
        val_wdata = add_sum;
      end
      S_RD: begin
        // clear after the read
        val_we   = 1'b1;
        val_addr = cur_q.position[POS_AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= head_i;
    end
    case (state_q)
      S_RS0: lo_q <= rs_clamped;
      S_RS1: begin
        end_q <= rs_clamped;
        hi_q  <= rs_clamped;
      end
      S_SRCH:  mid_q <= mid;
      S_PROBE: begin
        if (col_rdata_q < cur_q.column) begin
          lo_q <= mid_q + PW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && !out_stall_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + POS_AW'(1);
          if (clr_q == POS_AW'(MAX_NONZEROS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            case (head_i.op)
              OP_ACC:  state_q <= S_RS0;
              OP_READ: state_q <= S_RD;
              default: begin
                res_valid_q  <= 1'b1;
                res_pos_q    <= '0;
                res_sum_q    <= '0;
                res_status_q <= (head_i.op == OP_ZERO)   ? ST_ZERO :
                                (head_i.op == OP_ABSENT) ? ST_ABSENT : ST_DONE;
              end
            endcase
          end
        end
        S_RS0: state_q <= S_RS1;
        S_RS1: begin
          if (lo_q > rs_clamped) begin
            state_q      <= S_IDLE;
            res_valid_q  <= 1'b1;
            res_status_q <= ST_ABSENT;
            res_pos_q    <= '0;
            res_sum_q    <= '0;
          end else begin
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_q < hi_q) begin
            state_q <= S_PROBE;
          end else if (lo_q >= end_q) begin
            state_q      <= S_IDLE;
            res_valid_q  <= 1'b1;
            res_status_q <= ST_ABSENT;
            res_pos_q    <= '0;
            res_sum_q    <= '0;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_PROBE: state_q <= S_SRCH;
        S_CHK: begin
          if (col_rdata_q != cur_q.column) begin
            state_q      <= S_IDLE;
            res_valid_q  <= 1'b1;
            res_status_q <= ST_ABSENT;
            res_pos_q    <= '0;
            res_sum_q    <= '0;
          end else begin
            state_q <= S_VAL;
          end
        end
        S_VAL: state_q <= S_ADD;
        S_ADD: begin
          if (add_done) begin
            state_q      <= S_IDLE;
            res_valid_q  <= 1'b1;
            res_status_q <= ST_DONE;
            res_pos_q    <= 14'(32'(lo_q));
            res_sum_q    <= add_sum;
          end
        end
        S_RD: begin
          state_q      <= S_IDLE;
          res_valid_q  <= 1'b1;
          res_status_q <= ST_DONE;
          res_pos_q    <= cur_q.position[13:0];
          res_sum_q    <= val_rdata_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pop_o            = take;
  assign ready_o          = (state_q != S_CLEAR);
  assign out_valid_o      = res_valid_q;
  assign status_o         = res_status_q;
  assign found_position_o = res_pos_q;
  assign sum_o            = res_sum_q;

endmodule
`default_nettype wire

// ===== src/csr_scatter_accumulate.sv =====
// Scatter-add into a compressed-row sparse matrix.
// Input channel (in_valid_i / in_stall_o) carries one request: cmd_i selects
// load row start, load column index, accumulate, or read and clear. The
// output channel (out_valid_o / out_stall_i) returns exactly one result per
// request, in order: status, found position and the stored double.
// dof_count is to be written by the user through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block has no check for this. A two-entry queue
// decouples request intake from the execution engine. An accumulate reads the
// row bounds, runs a binary search over the column memory and then the double
// add. The engine handles one request at a time; the binary search and the
// multi-cycle adder set the rate. After reset the value store is swept to
// zero, one entry per cycle; in_stall_o stays high until the sweep ends.
// If out_stall_i holds a result, the engine waits and the queue fills, then
// in_stall_o rises.
`default_nettype none
module csr_scatter_accumulate import csa_pkg::*; #(
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned MAX_NONZEROS = MaxNzDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [10:0] row_i,
  input  wire logic [14:0] position_i,
  input  wire logic [9:0]  column_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [13:0]      found_position_o,
  output logic [63:0]      sum_o
);

  item_t head;
  logic  head_valid, pop, back_ready;

  csa_front #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .row_i        (row_i),
    .position_i   (position_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .back_ready_i (back_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  csa_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .ready_o          (back_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .sum_o            (sum_o)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import csa_pkg::*;

  localparam int unsigned NROWS  = MaxRowsDef;
  localparam int unsigned NNZ    = MaxNzDef;
  localparam int unsigned STALL_LIMIT = 80000;  // covers the clearing sweep after reset
  localparam int unsigned SETTLE = 60;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] pos;
    logic [63:0] sum;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd = CMD_LOAD_ROW;
  logic [10:0] row = '0;
  logic [14:0] position = '0;
  logic [9:0]  column = '0;
  logic [63:0] value = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [1:0]  status_o;
  logic [13:0] found_position_o;
  logic [63:0] sum_o;

  csr_scatter_accumulate dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o,
    .cmd_i(cmd), .row_i(row), .position_i(position), .column_i(column), .value_i(value),
    .out_valid_o, .out_stall_i(out_stall),
    .status_o, .found_position_o, .sum_o
  );

  // matrix image kept by the testbench
  logic [10:0] dofs;
  logic [14:0] row_starts [0:NROWS];
  bit          row_start_set [0:NROWS];
  logic [9:0]  col_idx [0:NNZ-1];
  bit          col_set [0:NNZ-1];
  logic [63:0] entries [0:NNZ-1];

  result_t     pending_q [$];
  int          hit_row [$];
  int          hit_col [$];
  int          errors = 0;
  int          n_req = 0, n_res = 0, n_hit = 0, n_absent = 0, n_zero = 0;
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;
  int          quiet_cnt = 0;
  int          pat_end;

  initial forever #10 clk_i = ~clk_i;

  function automatic int clamp_nz(int p);
    return (p > NNZ) ? NNZ : p;
  endfunction

  // true when a search on this row only touches written table entries
  function automatic bit row_searchable(int r);
    int lo, hi;
    if (r >= dofs || r >= NROWS) return 1'b1;
    if (!row_start_set[r] || !row_start_set[r+1]) return 1'b0;
    lo = clamp_nz(row_starts[r]);
    hi = clamp_nz(row_starts[r+1]);
    for (int i = lo; i < hi; i++) if (!col_set[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic result_t scatter_add(logic [1:0] c, int r, int p, int col,
                                          logic [63:0] v);
    result_t res;
    int lo, hi, stop, mid;
    res = '0;
    case (c)
      CMD_LOAD_ROW: if (r <= NROWS) begin
        row_starts[r] = 15'(p);
        row_start_set[r] = 1'b1;
      end
      CMD_LOAD_COL: if (p < NNZ) begin
        col_idx[p] = 10'(col);
        col_set[p] = 1'b1;
      end
      CMD_READ: begin
        if (p >= NNZ) res.status = ST_ABSENT;
        else begin
          res.pos = 14'(p);
          res.sum = entries[p];
          entries[p] = '0;
        end
      end
      default: begin
        if (v[62:0] == '0) res.status = ST_ZERO;
        else if (r >= dofs || r >= NROWS) res.status = ST_ABSENT;
        else begin
          lo = clamp_nz(row_starts[r]);
          stop = clamp_nz(row_starts[r+1]);
          hi = stop;
          if (lo > stop) res.status = ST_ABSENT;
          else begin
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (col_idx[mid] < col) lo = mid + 1;
              else hi = mid;
            end
            if (lo >= stop || col_idx[lo] != col) res.status = ST_ABSENT;
            else begin
              entries[lo] = $realtobits($bitstoreal(entries[lo]) + $bitstoreal(v));
              res.pos = 14'(lo);
              res.sum = entries[lo];
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report(string what, result_t got, result_t want);
    errors++;
    $display("MISMATCH %s: got st=%0d pos=%0d sum=%h, want st=%0d pos=%0d sum=%h",
             what, got.status, got.pos, got.sum, want.status, want.pos, want.sum);
  endtask

  // result checker, watchdog and receiver stall
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= STALL_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", quiet_cnt);
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid_o && !out_stall) begin
        got = '{status_o, found_position_o, sum_o};
        n_res++;
        if (pending_q.size() == 0) report("unexpected result", got, '0);
        else begin
          want = pending_q.pop_front();
          if (got.status != want.status) report("status", got, want);
          else if (got.pos != want.pos) report("position", got, want);
          else if (got.sum != want.sum) report("sum", got, want);
        end
      end
    end
  end

  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (left > 0) left--;
      else if (!idle_on) out_stall <= 1'b0;
      else begin
        case ($urandom_range(0, 9))
          0, 1:    begin out_stall <= 1'b1; left = $urandom_range(0, 3); end
          2:       begin out_stall <= 1'b1; left = $urandom_range(10, 40); end
          default: begin out_stall <= 1'b0; left = $urandom_range(0, 20); end
        endcase
      end
    end
  end

  task automatic send_req(logic [1:0] c, int r, int p, int col, logic [63:0] v);
    int gap;
    result_t want;
    gap = 0;
    if (idle_on) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd <= c; row <= 11'(r); position <= 15'(p); column <= 10'(col); value <= v;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = scatter_add(c, r, p, col, v);
    pending_q = {pending_q, want};
    n_req++;
    if (c == CMD_ACC) begin
      if (want.status == ST_DONE) n_hit++;
      else if (want.status == ST_ZERO) n_zero++;
      else n_absent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_dofs(int d);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= 11'(d);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    dofs = 11'(d);
  endtask

  function automatic logic [63:0] rand_double();
    case ($urandom_range(0, 9))
      0:       return {$urandom, $urandom};
      1:       return {1'($urandom_range(0, 1)), 11'h7ff, 52'd0};  // infinity
      default: return $realtobits(($urandom_range(0, 200000) - 100000.0) / 64.0
                                  + 0.015625);
    endcase
  endfunction

  task automatic acc_random();
    int r, col, k;
    logic [63:0] v;
    v = rand_double();
    if ($urandom_range(0, 19) == 0) v = {1'($urandom_range(0, 1)), 63'd0};
    k = $urandom_range(0, 9);
    if (k < 7 && hit_row.size() != 0) begin
      k = $urandom_range(0, hit_row.size() - 1);
      r = hit_row[k];
      col = hit_col[k];
    end else if (k < 9) begin
      r = $urandom_range(0, 20);
      col = $urandom_range(0, 1023);
    end else begin
      r = $urandom_range(0, 2047);
      col = $urandom_range(0, 1023);
    end
    if (!row_searchable(r)) r = 2047;
    send_req(CMD_ACC, r, $urandom_range(0, 32767), col, v);
  endtask

  // regular rows 0..11, an unsorted row, a row with begin past end,
  // and clamped row starts
  task automatic test_pattern_load();
    int p, cnt, c;
    int odd_cols [4] = '{500, 20, 900, 300};
    p = 0;
    for (int r = 0; r < 12; r++) begin
      send_req(CMD_LOAD_ROW, r, p, $urandom_range(0, 1023), {$urandom, $urandom});
      cnt = (r == 3) ? 0 : $urandom_range(1, 9);
      c = (r == 5) ? 0 : $urandom_range(0, 30);
      for (int i = 0; i < cnt && c <= 1023; i++) begin
        send_req(CMD_LOAD_COL, $urandom_range(0, 2047), p, c, {$urandom, $urandom});
        hit_row = {hit_row, r};
        hit_col = {hit_col, c};
        p++;
        c = (r == 5 && i == cnt - 2) ? 1023 : c + $urandom_range(1, 60);
      end
    end
    pat_end = p;
    send_req(CMD_LOAD_ROW, 12, p, 0, '0);
    foreach (odd_cols[i]) send_req(CMD_LOAD_COL, 0, p + i, odd_cols[i], '0);
    send_req(CMD_LOAD_ROW, 13, p + 4, 0, '0);
    send_req(CMD_LOAD_ROW, 14, p + 1, 0, '0);      // row 13 ends before it begins
    send_req(CMD_LOAD_ROW, 15, 20000, 0, '0);
    send_req(CMD_LOAD_ROW, 16, 32767, 0, '0);      // row 15 clamps to an empty range
    send_req(CMD_LOAD_ROW, 1023, 16384, 0, '0);
    send_req(CMD_LOAD_ROW, 1024, 16384, 0, '0);
    send_req(CMD_LOAD_ROW, 1025, 7, 0, '0);        // slots past the table are ignored
    send_req(CMD_LOAD_ROW, 2047, 32767, 1023, '1);
    send_req(CMD_LOAD_COL, 0, 16383, 1023, '0);
    send_req(CMD_LOAD_COL, 0, 16384, 5, '0);
    send_req(CMD_LOAD_COL, 0, 32767, 1023, '1);
  endtask

  task automatic test_edge_cases();
    int r;
    send_req(CMD_READ, 0, 0, 0, '0);
    send_req(CMD_READ, 0, 16383, 0, '0);
    send_req(CMD_READ, 0, 16384, 0, '0);
    send_req(CMD_READ, 2047, 32767, 1023, '1);
    send_req(CMD_ACC, 0, 0, hit_col[0], 64'h3ff0000000000000);  // dof_count still 0
    set_dofs(1024);
    send_req(CMD_ACC, 0, 0, hit_col[0], 64'h0);
    send_req(CMD_ACC, 0, 0, hit_col[0], 64'h8000000000000000);
    send_req(CMD_ACC, 0, 0, hit_col[0], 64'h3ff0000000000000);
    send_req(CMD_ACC, 0, 0, hit_col[0], 64'hbff8000000000000);
    foreach (hit_row[i]) if (hit_col[i] == 1023 || hit_col[i] == 0)
      send_req(CMD_ACC, hit_row[i], 0, hit_col[i], 64'h7fefffffffffffff);
    send_req(CMD_ACC, 12, 0, 20, 64'h4000000000000000);      // unsorted row
    send_req(CMD_ACC, 12, 0, 900, 64'h4000000000000000);
    send_req(CMD_ACC, 13, 0, 300, 64'h4000000000000000);     // begin past end
    send_req(CMD_ACC, 15, 0, 0, 64'h4000000000000000);
    send_req(CMD_ACC, 1023, 0, 1023, 64'h4000000000000000);
    send_req(CMD_ACC, 1024, 0, 0, 64'h4000000000000000);
    send_req(CMD_ACC, 2047, 0, 0, 64'h4000000000000000);
    send_req(CMD_ACC, 3, 0, hit_col[0], 64'h4000000000000000); // empty row
    send_req(CMD_ACC, 1, 0, 1023, 64'h7ff0000000000000);
    send_req(CMD_ACC, 1, 0, 1023, 64'hfff0000000000000);     // inf - inf
    send_req(CMD_READ, 0, pat_end - 1, 0, '0);
    for (int i = 0; i < 4; i++) send_req(CMD_READ, 0, i, 0, '0);
    r = hit_row[hit_row.size() - 1];
    send_req(CMD_ACC, r, 0, hit_col[hit_col.size() - 1], {$urandom, $urandom});
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) acc_random();
    drain();  // sender waits for every result before going on
    for (int i = 0; i < 6; i++) acc_random();
  endtask

  task automatic test_random(int n, int d);
    set_dofs(d);
    for (int i = 0; i < n; i++) begin
      idle_on = !(i >= n / 3 && i < n / 2);
      case ($urandom_range(0, 19))
        0:       send_req(CMD_LOAD_ROW, $urandom_range(40, 2047), $urandom_range(0, 32767),
                          $urandom_range(0, 1023), {$urandom, $urandom});
        1:       send_req(CMD_LOAD_COL, $urandom_range(0, 2047),
                          $urandom_range(16000, 32767), $urandom_range(0, 1023),
                          {$urandom, $urandom});
        2, 3:    send_req(CMD_READ, $urandom_range(0, 2047),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, pat_end + 4),
                          $urandom_range(0, 1023), {$urandom, $urandom});
        default: acc_random();
      endcase
    end
    idle_on = 1'b1;
  endtask

  initial begin
    dofs = '0;
    foreach (entries[i]) begin
      entries[i] = '0;
      col_set[i] = 1'b0;
      col_idx[i] = '0;
    end
    foreach (row_starts[i]) begin
      row_starts[i] = '0;
      row_start_set[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_dofs(0);
    test_pattern_load();
    test_edge_cases();
    test_backpressure();
    test_random(350, 1024);
    test_random(350, 9);
    test_random(350, 14);
    drain();
    $display("covered %0d requests, %0d results: %0d adds, %0d absent, %0d zero skips,",
             n_req, n_res, n_hit, n_absent, n_zero);
    $display("row-start and column loads, reads with clear, three row counts, back-pressure");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
